/* rtl/keds_pkg.sv */
// Shared types and constants for the keyed exclusive dispatch scheduler.
// No dependencies; keds_slots and the top level refer to it by scoped names.
package keds_pkg;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned KEY_BITS    = 16;

  // Stored key width: the key field carries 16 bits, only the low KEY_BITS count.
  localparam int unsigned KEY_W  = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SUBMIT   = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_CANCEL   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_CONNECT    = 2'd0,
    KIND_DISCONNECT = 2'd1,
    KIND_NEGOTIATE  = 2'd2,
    // Folds onto disconnect on the way in; never stored.
    KIND_ALIAS      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY_KEY = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_CHK,
    S_CMP,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] device_key;
    logic [1:0]  command_kind;
    logic [15:0] request_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        queued;
    logic        dispatch_valid;
    logic [15:0] dispatch_key;
    logic [1:0]  dispatch_kind;
    logic [15:0] dispatch_tag;
    logic        dispatch_active;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    kind_e            kind;
    logic [15:0]      tag;
  } wait_entry_t;

  // Slot table write command from the sequencer.
  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
  } slot_cmd_t;

  // Slot table lookup answer.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free_ok;
    logic [SLOT_W-1:0] free_idx;
  } slot_stat_t;

endpackage

/* rtl/keds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module keds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/keds_slots.sv */
// Slot table: one busy flag and key per slot, with a key matcher and free-slot finder.
// Depends on keds_pkg.
module keds_slots (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [keds_pkg::KEY_W-1:0]  lookup_key_i,
  input  keds_pkg::slot_cmd_t         cmd_i,
  output keds_pkg::slot_stat_t        stat_o
);

  logic [keds_pkg::SLOTS-1:0] valid_q;
  logic [keds_pkg::KEY_W-1:0] key_q [keds_pkg::SLOTS];
  logic [keds_pkg::SLOTS-1:0] match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.set_en) begin
      valid_q[cmd_i.idx] <= 1'b1;
    end else if (cmd_i.clr_en) begin
      valid_q[cmd_i.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_en) begin
      key_q[cmd_i.idx] <= cmd_i.key;
    end
  end

  always_comb begin
    stat_o = '0;
    for (int i = 0; i < keds_pkg::SLOTS; i++) begin
      match[i] = valid_q[i] && (key_q[i] == lookup_key_i);
    end
    stat_o.hit     = |match;
    stat_o.free_ok = ~&valid_q;
    // Scan downward so the lowest index wins.
    for (int i = keds_pkg::SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        stat_o.hit_idx = keds_pkg::SLOT_W'(i);
      end
      if (!valid_q[i]) begin
        stat_o.free_idx = keds_pkg::SLOT_W'(i);
      end
    end
  end

  // A key is busy in at most one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match))
    else $error("key busy in more than one slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.set_en |-> !valid_q[cmd_i.idx])
    else $error("dispatch onto a busy slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.clr_en |-> valid_q[cmd_i.idx])
    else $error("release of an idle slot");

endmodule

/* rtl/keyed_exclusive_dispatch_scheduler.sv */
// Top level of the keyed exclusive dispatch scheduler: sequencer, wait queue, result register.
// Depends on keds_pkg, keds_ram and keds_slots.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_item_i    | request item into the block
//   out     | out_valid_o, out_ready_i, out_item_o | one result item per request item
//
// An item that needs no queue scan (submit, completion with an empty queue or no busy slot
// for its key, cancel with an empty queue, unknown op) goes from its accept through the
// look-up step to the final step, where its result is registered.
// A completion or cancel walks the wait queue one entry a cycle through the single read
// port of the wait RAM, a completion matching each entry in the shared slot matcher and a
// cancel comparing its kind, key and tag, then closes the gap one entry a cycle.
// One item is in work at a time; in_ready_o is high only when the sequencer is idle.
// The result register lets the next item be accepted while a result waits to be taken;
// a stalled output only holds the sequencer in its final step. Reset is asynchronous,
// active low, and needs no clearing pass: the queue is tracked by its fill count.
module keyed_exclusive_dispatch_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  keds_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output keds_pkg::out_item_t out_item_o
);

  typedef struct packed {
    keds_pkg::op_e                op;
    logic [keds_pkg::KEY_W-1:0]   key;
    keds_pkg::kind_e              kind;
    logic [15:0]                  tag;
  } req_t;

  keds_pkg::state_e               state_q, state_d;
  req_t                           req_q, req_d;
  keds_pkg::out_item_t            res_q, res_d;
  keds_pkg::out_item_t            out_q, out_d;
  logic                           out_valid_q, out_valid_d;
  logic [keds_pkg::QIDX_W-1:0]    idx_q, idx_d;
  logic [keds_pkg::QCNT_W-1:0]    count_q, count_d;
  logic [keds_pkg::SLOT_W-1:0]    slot_q, slot_d;

  // Wait RAM ports
  logic                           ram_we;
  logic [keds_pkg::QIDX_W-1:0]    ram_waddr;
  keds_pkg::wait_entry_t          ram_wdata;
  logic [keds_pkg::QIDX_W-1:0]    ram_raddr;
  keds_pkg::wait_entry_t          ram_rdata;

  // Slot matcher
  logic [keds_pkg::KEY_W-1:0]     lookup_key;
  keds_pkg::slot_cmd_t            slot_cmd;
  keds_pkg::slot_stat_t           slot_stat;

  logic [keds_pkg::QCNT_W-1:0]    idx_p1, idx_p2;
  logic                           entry_hit;
  keds_pkg::kind_e                in_kind;

  keds_ram #(
    .WIDTH ($bits(keds_pkg::wait_entry_t)),
    .DEPTH (keds_pkg::QUEUE_DEPTH)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  keds_slots u_slots (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lookup_key_i (lookup_key),
    .cmd_i        (slot_cmd),
    .stat_o       (slot_stat)
  );

  // Kind 3 folds onto disconnect.
  assign in_kind = (in_item_i.command_kind == keds_pkg::KIND_ALIAS)
                   ? keds_pkg::KIND_DISCONNECT
                   : keds_pkg::kind_e'(in_item_i.command_kind);

  assign idx_p1 = keds_pkg::QCNT_W'(idx_q) + keds_pkg::QCNT_W'(1);
  assign idx_p2 = keds_pkg::QCNT_W'(idx_q) + keds_pkg::QCNT_W'(2);

  // During the scan the matcher checks the queue entry, otherwise the request key.
  assign lookup_key = (state_q == keds_pkg::S_CHK) ? ram_rdata.key : req_q.key;

  assign in_ready_o  = (state_q == keds_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= keds_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    slot_q <= slot_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    idx_d       = idx_q;
    count_d     = count_q;
    slot_d      = slot_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    slot_cmd    = '0;
    entry_hit   = 1'b0;

    unique case (state_q)
      keds_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d.op   = keds_pkg::op_e'(in_item_i.op);
          req_d.key  = in_item_i.device_key[keds_pkg::KEY_W-1:0];
          req_d.kind = in_kind;
          req_d.tag  = in_item_i.request_tag;
          res_d      = '0;
          state_d    = keds_pkg::S_LOOK;
        end
      end

      keds_pkg::S_LOOK: begin
        // Present queue head for a possible scan.
        ram_raddr = '0;
        state_d   = keds_pkg::S_FIN;
        case (req_q.op)
          keds_pkg::OP_SUBMIT: begin
            if (req_q.key == '0) begin
              res_d.status = keds_pkg::STAT_EMPTY_KEY;
            end else if (slot_stat.hit || !slot_stat.free_ok) begin
              if (count_q == keds_pkg::QCNT_W'(keds_pkg::QUEUE_DEPTH)) begin
                res_d.status = keds_pkg::STAT_OVERFLOW;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = count_q[keds_pkg::QIDX_W-1:0];
                ram_wdata.key  = req_q.key;
                ram_wdata.kind = req_q.kind;
                ram_wdata.tag  = req_q.tag;
                count_d        = count_q + keds_pkg::QCNT_W'(1);
                res_d.queued   = 1'b1;
              end
            end else begin
              // Direct start always takes the active role.
              slot_cmd.set_en       = 1'b1;
              slot_cmd.idx          = slot_stat.free_idx;
              slot_cmd.key          = req_q.key;
              res_d.dispatch_valid  = 1'b1;
              res_d.dispatch_key    = 16'(req_q.key);
              res_d.dispatch_kind   = req_q.kind;
              res_d.dispatch_tag    = req_q.tag;
              res_d.dispatch_active = 1'b1;
            end
          end
          keds_pkg::OP_COMPLETE: begin
            if (!slot_stat.hit) begin
              res_d.status = keds_pkg::STAT_NOT_FOUND;
            end else begin
              // Release the slot now; the scan sees it idle.
              slot_cmd.clr_en = 1'b1;
              slot_cmd.idx    = slot_stat.hit_idx;
              slot_d          = slot_stat.hit_idx;
              if (count_q != '0) begin
                idx_d   = '0;
                state_d = keds_pkg::S_CHK;
              end
            end
          end
          keds_pkg::OP_CANCEL: begin
            if (count_q == '0) begin
              res_d.status = keds_pkg::STAT_NOT_FOUND;
            end else begin
              idx_d   = '0;
              state_d = keds_pkg::S_CHK;
            end
          end
          default: begin
            // Unknown op: empty result, no state change.
          end
        endcase
      end

      keds_pkg::S_CHK: begin
        // Entry idx is on the read port; prefetch the next one.
        ram_raddr = idx_p1[keds_pkg::QIDX_W-1:0];
        if (req_q.op == keds_pkg::OP_COMPLETE) begin
          entry_hit = !slot_stat.hit;
        end else begin
          entry_hit = (ram_rdata.kind == keds_pkg::KIND_CONNECT) &&
                      (ram_rdata.key == req_q.key) && (ram_rdata.tag == req_q.tag);
        end
        if (entry_hit) begin
          if (req_q.op == keds_pkg::OP_COMPLETE) begin
            slot_cmd.set_en       = 1'b1;
            slot_cmd.idx          = slot_q;
            slot_cmd.key          = ram_rdata.key;
            res_d.dispatch_valid  = 1'b1;
            res_d.dispatch_key    = 16'(ram_rdata.key);
            res_d.dispatch_kind   = ram_rdata.kind;
            res_d.dispatch_tag    = ram_rdata.tag;
            res_d.dispatch_active = (ram_rdata.kind != keds_pkg::KIND_NEGOTIATE);
          end
          // Drop the entry: shift the tail down if there is one.
          if (idx_p1 < count_q) begin
            state_d = keds_pkg::S_CMP;
          end else begin
            count_d = count_q - keds_pkg::QCNT_W'(1);
            state_d = keds_pkg::S_FIN;
          end
        end else if (idx_p1 >= count_q) begin
          if (req_q.op == keds_pkg::OP_CANCEL) begin
            res_d.status = keds_pkg::STAT_NOT_FOUND;
          end
          state_d = keds_pkg::S_FIN;
        end else begin
          idx_d = idx_p1[keds_pkg::QIDX_W-1:0];
        end
      end

      keds_pkg::S_CMP: begin
        // Read data holds entry idx+1; move it to idx and fetch idx+2.
        ram_raddr = idx_p2[keds_pkg::QIDX_W-1:0];
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        idx_d     = idx_p1[keds_pkg::QIDX_W-1:0];
        if (idx_p2 >= count_q) begin
          count_d = count_q - keds_pkg::QCNT_W'(1);
          state_d = keds_pkg::S_FIN;
        end
      end

      keds_pkg::S_FIN: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = keds_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = keds_pkg::S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= keds_pkg::QCNT_W'(keds_pkg::QUEUE_DEPTH))
    else $error("wait queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ram_we |-> (keds_pkg::QCNT_W'(ram_waddr) <= count_q))
    else $error("wait queue write past the fill level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ram_we |-> (state_q == keds_pkg::S_LOOK || state_q == keds_pkg::S_CMP))
    else $error("wait queue write outside submit or compaction");

endmodule
